// ===== src/duplex_pump_alternator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the duplex pump alternator
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUPLEX_PUMP_ALTERNATOR_ASSERT_SVH
`define DUPLEX_PUMP_ALTERNATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dpa assertion failed");

`endif

// ===== src/dpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Duplex pump alternator package
// Field widths, register indexes, mode and event codes.
// ----------------------------------------------------------------------------
package dpa_pkg;

  localparam int unsigned PRESSURE_W  = 12;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned EVENT_W     = 3;
  localparam int unsigned FAULT_W     = 2;
  localparam int unsigned TIMER_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [FAULT_W-1:0] MAX_FAULTS   = 2'd3;
  localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
  localparam logic [TIMER_W-1:0] ON_TIME_RST  = 16'd3000;
  localparam logic [SAMPLE_BITS:0] SAMPLE_FULL =
      (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME   = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ONE  = 4'b0010,
    MODE_TWO  = 4'b0100,
    MODE_HALT = 4'b1000
  } mode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_BUSY      = 3'd0,
    EV_NO_DEMAND = 3'd1,
    EV_P1_OK     = 3'd2,
    EV_P1_FAIL   = 3'd3,
    EV_P2_OK     = 3'd4,
    EV_P2_FAIL   = 3'd5,
    EV_HALT      = 3'd6
  } event_e;

endpackage

// ===== src/dpa_if.sv =====
// ----------------------------------------------------------------------------
// Duplex pump alternator channel interfaces
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface dpa_in_if;
  logic                            valid;
  logic                            ready;
  logic [dpa_pkg::PRESSURE_W-1:0]  pressure_sample;
  logic                            flow_one;
  logic                            flow_two;
  logic                            sense_one;
  logic                            sense_two;
  logic                            both_buttons;

  modport source (output valid, pressure_sample, flow_one, flow_two, sense_one,
                  sense_two, both_buttons, input ready);
  modport sink (input valid, pressure_sample, flow_one, flow_two, sense_one,
                sense_two, both_buttons, output ready);
endinterface

interface dpa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_one;
  logic                          drive_two;
  logic [dpa_pkg::PCT_W-1:0]     pressure_pct;
  logic [dpa_pkg::EVENT_W-1:0]   event_res;
  logic                          halted;
  logic [dpa_pkg::FAULT_W-1:0]   fault_count;

  modport source (output valid, drive_one, drive_two, pressure_pct, event_res,
                  halted, fault_count, input ready);
  modport sink (input valid, drive_one, drive_two, pressure_pct, event_res,
                halted, fault_count, output ready);
endinterface

interface dpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpa_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [dpa_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/duplex_pump_alternator.sv =====
// ----------------------------------------------------------------------------
// Duplex pump alternator
// Lead/lag controller for two pumps, one request per millisecond tick.
// ----------------------------------------------------------------------------
//   channel  direction  content
//   in_i     sink       pressure sample, flow, sense and acknowledge per tick
//   out_o    source     drives, pressure percent, event, halt, fault count
//   cfg_i    sink       register index and write data, always ready
//
// One request per cycle while the result is not stalled: an input register
// feeds the control update, which loads the result register.
// The pump state advances as a request moves into the result register.
// A stalled result holds the pipeline; the input register still takes one
// request while the result waits. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
module duplex_pump_alternator (
  input  logic    clk_i,
  input  logic    rst_ni,
  dpa_in_if.sink  in_i,
  dpa_out_if.source out_o,
  dpa_cfg_if.sink cfg_i
);

  localparam int unsigned SB   = dpa_pkg::SAMPLE_BITS;
  localparam int unsigned PW   = dpa_pkg::PCT_W;
  localparam int unsigned PRODW = SB + PW;

  // Configuration registers.
  logic [7:0]                    setpoint_q;
  logic [7:0]                    start_thr_q;
  logic [dpa_pkg::TIMER_W-1:0]   on_time_q;

  // Input register.
  logic                          s1_valid_q;
  logic [SB-1:0]                 s1_sample_q;
  logic                          s1_flow_one_q;
  logic                          s1_flow_two_q;
  logic                          s1_sense_two_q;
  logic                          s1_ack_q;

  // Pump control state.
  dpa_pkg::mode_e                mode_q, mode_d;
  logic                          turn_one_q, turn_one_d;
  logic [dpa_pkg::TIMER_W-1:0]   timer_q, timer_d;
  logic                          pulsing_q, pulsing_d;
  logic [dpa_pkg::FAULT_W-1:0]   faults_q, faults_d;
  logic                          pair_second_q, pair_second_d;
  logic                          first_failed_q, first_failed_d;

  // Result register.
  logic                          out_valid_q;
  logic                          out_drive_one_q, out_drive_one_d;
  logic                          out_drive_two_q, out_drive_two_d;
  logic [PW-1:0]                 out_pct_q;
  dpa_pkg::event_e               out_event_q, out_event_d;
  logic                          out_halted_q;
  logic [dpa_pkg::FAULT_W-1:0]   out_faults_q, out_faults_d;

  logic out_free;
  logic advance;

  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign cfg_i.ready = 1'b1;

  // Percent scaling: x / (2^SB - 1) is x >> SB plus at most one, fixed by
  // one compare against the full-scale value.
  logic [PRODW-1:0] prod;
  logic [PW-1:0]    quot0;
  logic [SB:0]      rem0;
  logic [PW-1:0]    pct;

  assign prod  = (PRODW'(s1_sample_q) << 6) + (PRODW'(s1_sample_q) << 5)
               + (PRODW'(s1_sample_q) << 2);
  assign quot0 = prod[PRODW-1:SB];
  assign rem0  = {1'b0, prod[SB-1:0]} + (SB + 1)'(quot0);
  assign pct   = (rem0 >= dpa_pkg::SAMPLE_FULL) ? quot0 + PW'(1) : quot0;

  always_comb begin
    dpa_pkg::mode_e              m;
    logic [dpa_pkg::FAULT_W-1:0] f;
    logic                        puls;
    logic [dpa_pkg::TIMER_W-1:0] tmr;
    logic                        p1;
    logic                        flow;
    logic                        failed;
    logic                        differ;

    m    = mode_q;
    f    = faults_q;
    puls = pulsing_q;
    tmr  = timer_q;
    p1   = 1'b0;
    flow = 1'b0;
    failed = 1'b0;
    differ = 1'b0;

    turn_one_d     = turn_one_q;
    pair_second_d  = pair_second_q;
    first_failed_d = first_failed_q;
    out_event_d    = dpa_pkg::EV_BUSY;
    out_faults_d   = '0;
    out_drive_one_d = 1'b0;
    out_drive_two_d = 1'b0;

    if (mode_q == dpa_pkg::MODE_HALT) begin
      out_event_d = dpa_pkg::EV_HALT;
      if (s1_ack_q) begin
        m              = dpa_pkg::MODE_IDLE;
        pair_second_d  = 1'b0;
        first_failed_d = 1'b0;
      end
    end else begin
      if (m == dpa_pkg::MODE_IDLE) begin
        if ({1'b0, pct} <= start_thr_q) begin
          m    = (turn_one_q || !s1_sense_two_q) ? dpa_pkg::MODE_ONE : dpa_pkg::MODE_TWO;
          f    = '0;
          puls = 1'b0;
          tmr  = '0;
        end else begin
          // A tick without demand counts as a successful result of the pair.
          out_event_d    = dpa_pkg::EV_NO_DEMAND;
          pair_second_d  = !pair_second_q;
          first_failed_d = 1'b0;
        end
      end
      if (m == dpa_pkg::MODE_ONE || m == dpa_pkg::MODE_TWO) begin
        p1   = (m == dpa_pkg::MODE_ONE);
        flow = p1 ? s1_flow_one_q : s1_flow_two_q;
        if (puls) begin
          if (tmr <= dpa_pkg::TIMER_W'(1)) begin
            puls = 1'b0;
            tmr  = '0;
            if (!flow && f < 2'd3) begin
              f = f + 2'd1;
            end
          end else begin
            tmr = tmr - dpa_pkg::TIMER_W'(1);
          end
        end
        if (!puls) begin
          if (f < dpa_pkg::MAX_FAULTS && {1'b0, pct} <= setpoint_q) begin
            puls = 1'b1;
            tmr  = on_time_q;
          end else begin
            failed = (f >= dpa_pkg::MAX_FAULTS);
            differ = (p1 == turn_one_q);
            if (p1) begin
              out_event_d = failed ? dpa_pkg::EV_P1_FAIL : dpa_pkg::EV_P1_OK;
            end else begin
              out_event_d = failed ? dpa_pkg::EV_P2_FAIL : dpa_pkg::EV_P2_OK;
            end
            out_faults_d = f;
            f            = '0;
            turn_one_d   = !p1;
            m            = dpa_pkg::MODE_IDLE;
            if (!pair_second_q) begin
              pair_second_d  = 1'b1;
              first_failed_d = failed;
            end else begin
              pair_second_d  = 1'b0;
              first_failed_d = 1'b0;
              if (first_failed_q && failed && differ) begin
                m = dpa_pkg::MODE_HALT;
              end
            end
          end
        end
        if (puls) begin
          out_event_d     = dpa_pkg::EV_BUSY;
          out_faults_d    = f;
          out_drive_one_d = p1;
          out_drive_two_d = !p1;
        end
      end
    end

    mode_d    = m;
    faults_d  = f;
    pulsing_d = puls;
    timer_d   = tmr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      start_thr_q <= '0;
      on_time_q   <= dpa_pkg::ON_TIME_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        dpa_pkg::CFG_SETPOINT:  setpoint_q  <= cfg_i.wdata[7:0];
        dpa_pkg::CFG_START_THR: start_thr_q <= cfg_i.wdata[7:0];
        dpa_pkg::CFG_ON_TIME:   on_time_q   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_sample_q    <= in_i.pressure_sample[SB-1:0];
      s1_flow_one_q  <= in_i.flow_one;
      s1_flow_two_q  <= in_i.flow_two;
      s1_sense_two_q <= in_i.sense_two;
      s1_ack_q       <= in_i.both_buttons;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= dpa_pkg::MODE_IDLE;
      turn_one_q     <= 1'b1;
      timer_q        <= '0;
      pulsing_q      <= 1'b0;
      faults_q       <= '0;
      pair_second_q  <= 1'b0;
      first_failed_q <= 1'b0;
    end else if (advance) begin
      mode_q         <= mode_d;
      turn_one_q     <= turn_one_d;
      timer_q        <= timer_d;
      pulsing_q      <= pulsing_d;
      faults_q       <= faults_d;
      pair_second_q  <= pair_second_d;
      first_failed_q <= first_failed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_drive_one_q <= out_drive_one_d;
      out_drive_two_q <= out_drive_two_d;
      out_pct_q       <= pct;
      out_event_q     <= out_event_d;
      out_halted_q    <= (mode_d == dpa_pkg::MODE_HALT);
      out_faults_q    <= out_faults_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_one    = out_drive_one_q;
  assign out_o.drive_two    = out_drive_two_q;
  assign out_o.pressure_pct = out_pct_q;
  assign out_o.event_res    = out_event_q;
  assign out_o.halted       = out_halted_q;
  assign out_o.fault_count  = out_faults_q;

endmodule

// ===== src/dpa_checker.sv =====
// ----------------------------------------------------------------------------
// Duplex pump alternator port checker
// Watches the result channel and checks drive and event consistency.
// ----------------------------------------------------------------------------
`include "duplex_pump_alternator_assert.svh"

module dpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          drive_one_i,
  input logic                          drive_two_i,
  input logic [dpa_pkg::PCT_W-1:0]     pressure_pct_i,
  input logic [dpa_pkg::EVENT_W-1:0]   event_res_i,
  input logic                          halted_i,
  input logic [dpa_pkg::FAULT_W-1:0]   fault_count_i
);

  // A result that waits must not change under the consumer.
  `DPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable({drive_one_i, drive_two_i, pressure_pct_i, event_res_i, halted_i, fault_count_i}))

  // A drive is on exactly when the tick reports a busy attempt.
  `DPA_ASSERT_IMP(a_drive_busy, clk_i, rst_ni, out_valid_i,
    ((drive_one_i || drive_two_i) == (event_res_i == dpa_pkg::EV_BUSY)) && !(drive_one_i && drive_two_i))

  // The halt is only entered on a failure tick or while already halted.
  `DPA_ASSERT_IMP(a_halt_event, clk_i, rst_ni, out_valid_i && halted_i,
    event_res_i == dpa_pkg::EV_P1_FAIL || event_res_i == dpa_pkg::EV_P2_FAIL || event_res_i == dpa_pkg::EV_HALT)

  // The scaled pressure never exceeds full scale.
  `DPA_ASSERT_IMP(a_pct_range, clk_i, rst_ni, out_valid_i,
    pressure_pct_i <= dpa_pkg::PCT_FULL)

endmodule

bind duplex_pump_alternator dpa_checker u_dpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .drive_one_i    (out_o.drive_one),
  .drive_two_i    (out_o.drive_two),
  .pressure_pct_i (out_o.pressure_pct),
  .event_res_i    (out_o.event_res),
  .halted_i       (out_o.halted),
  .fault_count_i  (out_o.fault_count)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplex pump alternator testbench
// Drives millisecond ticks with random gaps and result stalls. A behavioral
// copy of the lead/lag controller predicts every result, and each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [dpa_pkg::PRESSURE_W-1:0] sample;
    logic                           flow_one;
    logic                           flow_two;
    logic                           sense_one;
    logic                           sense_two;
    logic                           both_buttons;
  } tick_t;

  typedef struct packed {
    logic                        drive_one;
    logic                        drive_two;
    logic [dpa_pkg::PCT_W-1:0]   pct;
    dpa_pkg::event_e             ev;
    logic                        halted;
    logic [dpa_pkg::FAULT_W-1:0] faults;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  dpa_in_if  tick_ch ();
  dpa_out_if result_ch ();
  dpa_cfg_if cfg_ch ();

  duplex_pump_alternator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  // Shadow registers and controller state of the predictor.
  logic [7:0]                  setpoint_pct;
  logic [7:0]                  start_thr_pct;
  logic [dpa_pkg::TIMER_W-1:0] on_time_ms;
  dpa_pkg::mode_e              pump_mode;
  logic                        turn_one;
  logic [dpa_pkg::TIMER_W-1:0] pulse_timer;
  logic                        pulsing;
  logic [dpa_pkg::FAULT_W-1:0] fault_tally;
  logic                        pair_second;
  logic                        first_failed;

  outcome_t    expected_outcomes[$];
  int unsigned tick_gap_pct;
  int unsigned result_stall_pct;
  int unsigned stall_left;
  int unsigned mismatch_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned attempts_ok;
  int unsigned attempts_failed;
  int unsigned halt_ticks;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", expected_outcomes.size());
    $display("FAIL duplex_pump_alternator");
    $finish;
  end

  function automatic int unsigned idle_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // Results are grouped in pairs; two failures on different pumps latch the halt.
  function automatic void record_pair(logic failed, logic differ);
    if (!pair_second) begin
      pair_second  = 1'b1;
      first_failed = failed;
    end else begin
      if (first_failed && failed && differ) pump_mode = dpa_pkg::MODE_HALT;
      pair_second  = 1'b0;
      first_failed = 1'b0;
    end
  endfunction

  function automatic outcome_t pump_outcome(tick_t t);
    outcome_t    o;
    int unsigned pct;
    logic        active_one;
    logic        flow;
    logic        failed;
    logic        differ;
    o = '0;
    o.ev = dpa_pkg::EV_BUSY;
    pct = (int'(t.sample) * int'(dpa_pkg::PCT_FULL)) / int'(dpa_pkg::SAMPLE_FULL);
    if (pump_mode == dpa_pkg::MODE_HALT) begin
      o.ev = dpa_pkg::EV_HALT;
      if (t.both_buttons) begin
        pump_mode    = dpa_pkg::MODE_IDLE;
        pair_second  = 1'b0;
        first_failed = 1'b0;
      end
    end else begin
      if (pump_mode == dpa_pkg::MODE_IDLE) begin
        if (pct <= start_thr_pct) begin
          pump_mode   = (turn_one || !t.sense_two) ? dpa_pkg::MODE_ONE : dpa_pkg::MODE_TWO;
          fault_tally = '0;
          pulsing     = 1'b0;
          pulse_timer = '0;
        end else begin
          o.ev = dpa_pkg::EV_NO_DEMAND;
          record_pair(1'b0, 1'b0);
        end
      end
      if (pump_mode == dpa_pkg::MODE_ONE || pump_mode == dpa_pkg::MODE_TWO) begin
        active_one = (pump_mode == dpa_pkg::MODE_ONE);
        if (pulsing) begin
          if (pulse_timer <= 1) begin
            flow        = active_one ? t.flow_one : t.flow_two;
            pulsing     = 1'b0;
            pulse_timer = '0;
            if (!flow && fault_tally < dpa_pkg::MAX_FAULTS) fault_tally++;
          end else begin
            pulse_timer--;
          end
        end
        if (!pulsing) begin
          if (fault_tally < dpa_pkg::MAX_FAULTS && pct <= setpoint_pct) begin
            pulsing     = 1'b1;
            pulse_timer = on_time_ms;
          end else begin
            failed = (fault_tally >= dpa_pkg::MAX_FAULTS);
            differ = (active_one == turn_one);
            if (active_one) o.ev = failed ? dpa_pkg::EV_P1_FAIL : dpa_pkg::EV_P1_OK;
            else o.ev = failed ? dpa_pkg::EV_P2_FAIL : dpa_pkg::EV_P2_OK;
            o.faults    = fault_tally;
            fault_tally = '0;
            turn_one    = !active_one;
            pump_mode   = dpa_pkg::MODE_IDLE;
            record_pair(failed, differ);
          end
        end
        if (pulsing) begin
          o.ev     = dpa_pkg::EV_BUSY;
          o.faults = fault_tally;
          if (active_one) o.drive_one = 1'b1;
          else o.drive_two = 1'b1;
        end
      end
    end
    o.pct    = dpa_pkg::PCT_W'(pct);
    o.halted = (pump_mode == dpa_pkg::MODE_HALT);
    return o;
  endfunction

  // Result side: random stalls, with stretches of none when the percentage is zero.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < result_stall_pct) stall_left = idle_length();
    end
  end

  // Predict on every accepted tick, then check any accepted result.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    tick_t    t;
    if (rst_ni) begin
      if (tick_ch.valid && tick_ch.ready) begin
        t = {tick_ch.pressure_sample, tick_ch.flow_one, tick_ch.flow_two,
             tick_ch.sense_one, tick_ch.sense_two, tick_ch.both_buttons};
        expected_outcomes.push_back(pump_outcome(t));
        ticks_sent++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got.drive_one = result_ch.drive_one;
        got.drive_two = result_ch.drive_two;
        got.pct       = result_ch.pressure_pct;
        got.ev        = dpa_pkg::event_e'(result_ch.event_res);
        got.halted    = result_ch.halted;
        got.faults    = result_ch.fault_count;
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with no tick pending: %p", $realtime, got);
        end else begin
          want = expected_outcomes.pop_front();
          results_checked++;
          if (want.ev == dpa_pkg::EV_P1_OK || want.ev == dpa_pkg::EV_P2_OK) attempts_ok++;
          if (want.ev == dpa_pkg::EV_P1_FAIL || want.ev == dpa_pkg::EV_P2_FAIL)
            attempts_failed++;
          if (want.ev == dpa_pkg::EV_HALT) halt_ticks++;
          if (got.drive_one !== want.drive_one || got.drive_two !== want.drive_two ||
              got.pct !== want.pct || got.ev !== want.ev ||
              got.halted !== want.halted || got.faults !== want.faults) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: result %0d mismatch, expected %p, got %p",
                       $realtime, results_checked, want, got);
          end
        end
      end
    end
  end

  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < tick_gap_pct) ? idle_length() : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid           <= 1'b1;
    tick_ch.pressure_sample <= t.sample;
    tick_ch.flow_one        <= t.flow_one;
    tick_ch.flow_two        <= t.flow_two;
    tick_ch.sense_one       <= t.sense_one;
    tick_ch.sense_two       <= t.sense_two;
    tick_ch.both_buttons    <= t.both_buttons;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  task automatic drive_tick(logic [dpa_pkg::PRESSURE_W-1:0] sample, logic f1, logic f2,
                            logic s1, logic s2, logic btn);
    send_tick({sample, f1, f2, s1, s2, btn});
  endtask

  // Holds the tick channel until every predicted result has been checked.
  task automatic await_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_outcomes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [dpa_pkg::CFG_IDX_W-1:0] idx,
                                logic [dpa_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      dpa_pkg::CFG_SETPOINT:  setpoint_pct  = data[7:0];
      dpa_pkg::CFG_START_THR: start_thr_pct = data[7:0];
      dpa_pkg::CFG_ON_TIME:   on_time_ms    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Upper bits of the byte-wide registers carry noise; the block ignores them.
  task automatic configure(logic [7:0] setpoint, logic [7:0] threshold,
                           logic [dpa_pkg::TIMER_W-1:0] on_time);
    write_register(dpa_pkg::CFG_SETPOINT, {8'($urandom), setpoint});
    write_register(dpa_pkg::CFG_START_THR, {8'($urandom), threshold});
    write_register(dpa_pkg::CFG_ON_TIME, on_time);
  endtask

  // With reset values only a zero percent reading creates demand.
  task automatic test_no_demand_after_reset();
    tick_gap_pct     = 30;
    result_stall_pct = 30;
    drive_tick(12'd4095, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    drive_tick(12'd41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    drive_tick(12'd2048, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    drive_tick(12'd4095, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    await_results();
  endtask

  // Hand-built lead/lag sequence with a one-tick pulse, the start tick ending an
  // attempt at once, out-of-turn start, two failed attempts latching the halt,
  // and the acknowledge that clears it.
  task automatic test_lead_lag_sequence();
    configure(8'd40, 8'd50, 16'd0);
    tick_gap_pct     = 25;
    result_stall_pct = 25;
    drive_tick(12'd1843, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd1843, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    drive_tick(12'd1843, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    drive_tick(12'd410, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    drive_tick(12'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    drive_tick(12'd4095, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    drive_tick(12'd4095, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    drive_tick(12'd410, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_tick(12'd410, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    drive_tick(12'd4095, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    await_results();
  endtask

  // Pressure moves in bands of random length: mostly demand or the pumping
  // window, sometimes above the setpoint, sometimes raw noise.
  task automatic run_pressure_profile(int unsigned n_ticks, int unsigned flow_ok_pct);
    tick_t       t;
    int unsigned seg_left;
    int unsigned band;
    int unsigned flow_pct;
    int unsigned lo;
    int unsigned hi;
    int unsigned thr_c;
    int unsigned sp_c;
    seg_left = 0;
    band     = 0;
    flow_pct = flow_ok_pct;
    thr_c    = (start_thr_pct > 100) ? 100 : start_thr_pct;
    sp_c     = (setpoint_pct > 100) ? 100 : setpoint_pct;
    repeat (n_ticks) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 24);
        band     = $urandom_range(0, 9);
        flow_pct = ($urandom_range(0, 3) != 0) ? flow_ok_pct : 100 - flow_ok_pct;
      end
      seg_left--;
      if (band <= 4) begin
        lo = 0;
        hi = thr_c;
      end else if (band <= 6) begin
        lo = thr_c + 1;
        hi = sp_c;
      end else begin
        lo = sp_c + 1;
        hi = 100;
      end
      // Rounding the sample up makes it scale back to exactly the chosen percent.
      if (band == 9 || lo > hi) t.sample = dpa_pkg::PRESSURE_W'($urandom);
      else t.sample = dpa_pkg::PRESSURE_W'(($urandom_range(lo, hi) * 4095 + 99) / 100);
      t.flow_one     = ($urandom_range(0, 99) < flow_pct);
      t.flow_two     = ($urandom_range(0, 99) < flow_pct);
      t.sense_one    = 1'($urandom_range(0, 1));
      t.sense_two    = ($urandom_range(0, 99) < 85);
      t.both_buttons = ($urandom_range(0, 99) < 8);
      send_tick(t);
    end
  endtask

  task automatic test_mixed_flow();
    configure(8'd70, 8'd35, 16'd2);
    tick_gap_pct     = 20;
    result_stall_pct = 20;
    run_pressure_profile(300, 70);
    await_results();
  endtask

  // Always demand and never satisfied: attempts end only through faults.
  task automatic test_saturated_thresholds();
    configure(8'd255, 8'd255, 16'd0);
    tick_gap_pct     = 0;
    result_stall_pct = 0;
    run_pressure_profile(200, 30);
    await_results();
  endtask

  task automatic test_zero_thresholds();
    configure(8'd0, 8'd0, 16'd2);
    tick_gap_pct     = 50;
    result_stall_pct = 10;
    run_pressure_profile(150, 50);
    await_results();
  endtask

  // Longer pulses; the sender also waits for a full drain halfway through.
  task automatic test_long_pulses();
    configure(8'd90, 8'd60, 16'd12);
    tick_gap_pct     = 10;
    result_stall_pct = 40;
    run_pressure_profile(150, 60);
    await_results();
    run_pressure_profile(150, 60);
    await_results();
  endtask

  task automatic test_full_scale_limits();
    configure(8'd100, 8'd100, 16'd5);
    tick_gap_pct     = 30;
    result_stall_pct = 30;
    run_pressure_profile(150, 85);
    await_results();
  endtask

  // Largest on time with no demand possible, so no pulse ever loads it.
  task automatic test_max_on_time();
    configure(8'd0, 8'd0, 16'hFFFF);
    tick_gap_pct     = 20;
    result_stall_pct = 20;
    repeat (30) begin
      drive_tick(dpa_pkg::PRESSURE_W'($urandom_range(41, 4095)), 1'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(0, 99) < 20));
    end
    await_results();
  endtask

  initial begin
    rst_ni                  = 1'b0;
    tick_ch.valid           = 1'b0;
    tick_ch.pressure_sample = '0;
    tick_ch.flow_one        = 1'b0;
    tick_ch.flow_two        = 1'b0;
    tick_ch.sense_one       = 1'b0;
    tick_ch.sense_two       = 1'b0;
    tick_ch.both_buttons    = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.reg_index        = '0;
    cfg_ch.wdata            = '0;
    result_ch.ready         = 1'b0;
    stall_left              = 0;
    tick_gap_pct            = 0;
    result_stall_pct        = 0;
    mismatch_count          = 0;
    ticks_sent              = 0;
    results_checked         = 0;
    attempts_ok             = 0;
    attempts_failed         = 0;
    halt_ticks              = 0;
    setpoint_pct            = '0;
    start_thr_pct           = '0;
    on_time_ms              = dpa_pkg::ON_TIME_RST;
    pump_mode               = dpa_pkg::MODE_IDLE;
    turn_one                = 1'b1;
    pulse_timer             = '0;
    pulsing                 = 1'b0;
    fault_tally             = '0;
    pair_second             = 1'b0;
    first_failed            = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_demand_after_reset();
    test_lead_lag_sequence();
    test_mixed_flow();
    test_saturated_thresholds();
    test_zero_thresholds();
    test_long_pulses();
    test_full_scale_limits();
    test_max_on_time();

    repeat (8) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      mismatch_count++;
      $display("%0d predicted results never arrived", expected_outcomes.size());
    end
    $display("Sent %0d ticks and checked %0d results across eight register settings.",
             ticks_sent, results_checked);
    $display("Attempts: %0d succeeded, %0d failed; %0d ticks spent halted; %0d mismatches.",
             attempts_ok, attempts_failed, halt_ticks, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS duplex_pump_alternator");
    end else begin
      $display("FAIL duplex_pump_alternator");
    end
    $finish;
  end

endmodule
